### rtl/lpd_pkg.sv
// shared types and constants of the length prefix deframer
package lpd_pkg;

    // width of the max frame length register
    localparam int unsigned REG_BITS = 27;
    // length prefix is four bytes, big-endian
    localparam int unsigned LEN_BITS = 32;
    localparam int unsigned SHIFT_BITS = 24;
    localparam logic [1:0] HDR_LAST = 2'd3;
    localparam logic [REG_BITS-1:0] MAX_LEN_RESET = 27'd67108864;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_payload;
        logic       last_of_frame;
        logic       empty_frame;
        logic       oversize_error;
    } t_result;

endpackage

### rtl/lpd_core.sv
// deframer state: header collection, length check, payload count, sticky error
module lpd_core #(
    parameter int unsigned MAX_LEN_BITS = 27
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lpd_pkg::REG_BITS-1:0] i_cfg_wdata,
    input  logic                         i_accept,
    input  logic [7:0]                   i_in_byte,
    output logic                         o_has_result,
    output lpd_pkg::t_result             o_result
);

    localparam logic [lpd_pkg::LEN_BITS:0] LEN_MASK =
        (33'd1 << MAX_LEN_BITS) - 33'd1;

    logic [lpd_pkg::REG_BITS-1:0]   r_max_len;
    logic                           r_in_payload, n_in_payload;
    logic [1:0]                     r_hdr_cnt, n_hdr_cnt;
    logic [lpd_pkg::SHIFT_BITS-1:0] r_shift, n_shift;
    logic [MAX_LEN_BITS-1:0]        r_left, n_left;
    logic                           r_err, n_err;

    logic [lpd_pkg::LEN_BITS-1:0]   len_full;
    logic                           oversize;

    assign len_full = {r_shift, i_in_byte};
    assign oversize =
        (len_full > {{(lpd_pkg::LEN_BITS-lpd_pkg::REG_BITS){1'b0}}, r_max_len}) ||
        ({1'b0, len_full} > LEN_MASK);

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_shift      = r_shift;
        n_left       = r_left;
        n_err        = r_err;
        o_has_result = 1'b0;
        o_result     = '0;
        if (i_accept) begin
            if (r_err) begin
                o_has_result            = 1'b1;
                o_result.oversize_error = 1'b1;
            end else if (r_in_payload) begin
                n_left              = r_left - MAX_LEN_BITS'(1);
                o_has_result        = 1'b1;
                o_result.out_byte   = i_in_byte;
                o_result.is_payload = 1'b1;
                if (n_left == '0) begin
                    n_in_payload           = 1'b0;
                    o_result.last_of_frame = 1'b1;
                end
            end else if (r_hdr_cnt != lpd_pkg::HDR_LAST) begin
                n_shift   = {r_shift[lpd_pkg::SHIFT_BITS-9:0], i_in_byte};
                n_hdr_cnt = r_hdr_cnt + 2'd1;
            end else begin
                n_hdr_cnt = '0;
                n_shift   = '0;
                if (oversize) begin
                    n_err                   = 1'b1;
                    o_has_result            = 1'b1;
                    o_result.oversize_error = 1'b1;
                end else if (len_full == '0) begin
                    o_has_result           = 1'b1;
                    o_result.last_of_frame = 1'b1;
                    o_result.empty_frame   = 1'b1;
                end else begin
                    n_left       = len_full[MAX_LEN_BITS-1:0];
                    n_in_payload = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= lpd_pkg::MAX_LEN_RESET;
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_shift      <= '0;
            r_left       <= '0;
            r_err        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_shift      <= n_shift;
            r_left       <= n_left;
            r_err        <= n_err;
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err) else $error("error flag cleared without reset");

    a_err_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !r_in_payload) else $error("payload active while in error");

    a_payload_hdr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_hdr_cnt == '0 && r_left != '0))
        else $error("payload state inconsistent with header count");

endmodule

### rtl/lpd_out_reg.sv
// result register between the deframer logic and the output channel
module lpd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lpd_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_can_take,
    output logic             o_valid,
    output lpd_pkg::t_result o_result
);

    logic             r_valid;
    lpd_pkg::t_result r_result;

    // a new request may enter when the slot is empty or drains this cycle
    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_result.empty_frame |-> r_result.last_of_frame)
        else $error("empty frame without last flag");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || i_ready)) else $error("result overwritten");

    a_err_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_result.oversize_error |-> !r_result.is_payload)
        else $error("payload flagged on error result");

endmodule

### rtl/length_prefix_deframer.sv
// top level of the length prefix deframer
// splits a byte stream into frames, each a 4-byte big-endian length followed by
// that many payload bytes, and forwards payload bytes as they arrive. header
// bytes give no result, except the fourth when the length is zero (one empty
// frame result) or above max_frame_len / outside MAX_LEN_BITS (error result).
// after an oversize length every byte gives an error result until reset.
// one input byte is taken per clock while the output register can take it: the
// state update and length compare sit in one combinational step, and the result
// lands in a single output register that takes bytes while it is empty or its
// previous result leaves this cycle, so a result is seen in the cycle after its
// byte is taken. max_frame_len writes apply to headers completing after the write.
module length_prefix_deframer #(
    parameter int unsigned MAX_LEN_BITS = 27
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: max frame length
    input  logic                         i_cfg_we,
    input  logic [lpd_pkg::REG_BITS-1:0] i_cfg_wdata,
    // byte stream in
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_in_byte,
    // frame results out
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_out_byte,
    output logic                         o_is_payload,
    output logic                         o_last_of_frame,
    output logic                         o_empty_frame,
    output logic                         o_oversize_error
);

    logic             in_accept;
    logic             has_result;
    lpd_pkg::t_result core_result;
    lpd_pkg::t_result out_result;

    // input request taken when the result slot can absorb it
    assign in_accept = i_in_valid && o_in_ready;

    lpd_core #(
        .MAX_LEN_BITS(MAX_LEN_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_in_byte   (i_in_byte),
        .o_has_result(has_result),
        .o_result    (core_result)
    );

    // only bytes that produce a result load the output register
    lpd_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_accept && has_result),
        .i_result  (core_result),
        .i_ready   (i_out_ready),
        .o_can_take(o_in_ready),
        .o_valid   (o_out_valid),
        .o_result  (out_result)
    );

    assign o_out_byte       = out_result.out_byte;
    assign o_is_payload     = out_result.is_payload;
    assign o_last_of_frame  = out_result.last_of_frame;
    assign o_empty_frame    = out_result.empty_frame;
    assign o_oversize_error = out_result.oversize_error;

endmodule
